// ===== hw/rtl/mktd_pkg.sv =====
// Shared types, constants and the Morse letter table for the key timing decoder.
// No dependencies; used by morse_key_timing_decoder_top.
package mktd_pkg;

    localparam int MAX_SYMBOLS_DEF = 5;
    localparam int TIME_W          = 16;
    localparam int CODE_W          = 7;
    localparam int CFG_ADDR_W      = 2;
    localparam int TABLE_SYMS      = 5;    // longest pattern in the letter table

    // register indexes on the config port
    localparam logic [CFG_ADDR_W-1:0] CFG_SHORT_MIN  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_DOT_MAX    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_DASH_MAX   = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_LETTER_GAP = 2'd3;

    localparam logic [TIME_W-1:0] SHORT_MIN_RST  = 16'd469;
    localparam logic [TIME_W-1:0] DOT_MAX_RST    = 16'd3125;
    localparam logic [TIME_W-1:0] DASH_MAX_RST   = 16'd6250;
    localparam logic [TIME_W-1:0] LETTER_GAP_RST = 16'd6250;

    typedef enum logic [1:0] {
        SYM_NONE = 2'd0,
        SYM_DOT  = 2'd1,
        SYM_DASH = 2'd2
    } t_sym;

    // count: number of symbols, bits: bit i set for a dash at position i
    function automatic logic [CODE_W-1:0] morse_lookup(input logic [2:0] count,
                                                       input logic [TABLE_SYMS-1:0] bits);
        logic [CODE_W-1:0] code;
        code = '0;
        case ({count, bits})
            {3'd2, 5'd2}:  code = 7'd65;  // A
            {3'd4, 5'd1}:  code = 7'd66;  // B
            {3'd4, 5'd5}:  code = 7'd67;  // C
            {3'd3, 5'd1}:  code = 7'd68;  // D
            {3'd1, 5'd0}:  code = 7'd69;  // E
            {3'd4, 5'd4}:  code = 7'd70;  // F
            {3'd3, 5'd3}:  code = 7'd71;  // G
            {3'd4, 5'd0}:  code = 7'd72;  // H
            {3'd2, 5'd0}:  code = 7'd73;  // I
            {3'd4, 5'd14}: code = 7'd74;  // J
            {3'd3, 5'd5}:  code = 7'd75;  // K
            {3'd4, 5'd2}:  code = 7'd76;  // L
            {3'd2, 5'd3}:  code = 7'd77;  // M
            {3'd2, 5'd1}:  code = 7'd78;  // N
            {3'd3, 5'd7}:  code = 7'd79;  // O
            {3'd4, 5'd6}:  code = 7'd80;  // P
            {3'd4, 5'd11}: code = 7'd81;  // Q
            {3'd3, 5'd2}:  code = 7'd82;  // R
            {3'd3, 5'd0}:  code = 7'd83;  // S
            {3'd1, 5'd1}:  code = 7'd84;  // T
            {3'd3, 5'd4}:  code = 7'd85;  // U
            {3'd4, 5'd8}:  code = 7'd86;  // V
            {3'd3, 5'd6}:  code = 7'd87;  // W
            {3'd4, 5'd9}:  code = 7'd88;  // X
            {3'd4, 5'd13}: code = 7'd89;  // Y
            {3'd4, 5'd3}:  code = 7'd90;  // Z
            {3'd5, 5'd30}: code = 7'd49;  // 1
            {3'd5, 5'd28}: code = 7'd50;  // 2
            {3'd5, 5'd24}: code = 7'd51;  // 3
            {3'd5, 5'd16}: code = 7'd52;  // 4
            {3'd5, 5'd0}:  code = 7'd53;  // 5
            {3'd5, 5'd1}:  code = 7'd54;  // 6
            {3'd5, 5'd3}:  code = 7'd55;  // 7
            {3'd5, 5'd7}:  code = 7'd56;  // 8
            {3'd5, 5'd15}: code = 7'd57;  // 9
            {3'd5, 5'd31}: code = 7'd48;  // 0
            default:       code = '0;
        endcase
        return code;
    endfunction

endpackage

// ===== hw/rtl/morse_key_timing_decoder_top.sv =====
// Morse key timing decoder: classifies press lengths into dots and dashes,
// closes letters on long gaps or timer overflow and looks up the character.
// Depends on mktd_pkg.
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tuser: kind, tdata: capture_time
//  m_axis    out  m_axis_tvalid/m_axis_tready  tlast: letter_end,
//                                              tdata: symbol_kind, char_valid, char_code
//  cfg       in   i_cfg_we                     i_cfg_addr, i_cfg_data
//
// One item per cycle while the output is not stalled: the span compare, symbol shift and
// table lookup run in the accepting cycle and the result is captured in the output register.
// Overflow ticks update state only and produce no result.
// s_axis_tready stays high while the output register is empty or being drained.
// Synchronous active-low reset returns the decoder state, output valid and the config registers to defaults.
module morse_key_timing_decoder_top #(
    parameter int MAX_SYMBOLS = mktd_pkg::MAX_SYMBOLS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mktd_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [mktd_pkg::TIME_W-1:0]         i_cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [15:0]                         s_axis_tdata,  // [15:0] capture_time
    input  logic                                s_axis_tuser,  // [0] kind
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [1:0] symbol_kind, [2] char_valid, [9:3] char_code, [15:10] zero
    output logic [15:0]                         m_axis_tdata,
    output logic                                m_axis_tlast   // letter_end
);

    localparam int SYM_W = MAX_SYMBOLS;
    localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);
    localparam int EXT_W = (SYM_W > mktd_pkg::TABLE_SYMS) ? SYM_W : mktd_pkg::TABLE_SYMS;
    localparam int TW    = mktd_pkg::TIME_W;

    // config registers
    logic [TW-1:0] r_short_min, r_dot_max, r_dash_max, r_letter_gap;

    // decoder state
    logic             r_await_rel, n_await_rel;
    logic [TW-1:0]    r_last, n_last;
    logic             r_ovf, n_ovf;
    logic [SYM_W-1:0] r_bits, n_bits;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_overrun, n_overrun;

    // result register
    logic                        r_out_valid;
    mktd_pkg::t_sym              r_sym, n_sym;
    logic                        r_lend, n_lend;
    logic                        r_cval, n_cval;
    logic [mktd_pkg::CODE_W-1:0] r_code, n_code;

    logic                        accept;
    logic [TW-1:0]               span;
    logic [EXT_W-1:0]            bits_ext;
    logic [mktd_pkg::CODE_W-1:0] lookup_code;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign span          = s_axis_tdata - r_last + TW'(1);
    assign bits_ext      = EXT_W'(r_bits);

    always_comb begin
        if (r_overrun || (r_count == '0) || (r_count > CNT_W'(mktd_pkg::TABLE_SYMS))) begin
            lookup_code = '0;
        end else begin
            lookup_code = mktd_pkg::morse_lookup(3'(r_count),
                                                 bits_ext[mktd_pkg::TABLE_SYMS-1:0]);
        end
    end

    always_comb begin
        n_await_rel = r_await_rel;
        n_last      = r_last;
        n_ovf       = r_ovf;
        n_bits      = r_bits;
        n_count     = r_count;
        n_overrun   = r_overrun;
        n_sym       = mktd_pkg::SYM_NONE;
        n_lend      = 1'b0;
        n_cval      = 1'b0;
        n_code      = '0;
        if (s_axis_tuser) begin
            n_ovf = 1'b1;
        end else if (r_await_rel) begin
            if (!r_ovf) begin
                if (span >= r_short_min && span <= r_dot_max) begin
                    n_sym = mktd_pkg::SYM_DOT;
                end else if (span > r_dot_max && span <= r_dash_max) begin
                    n_sym = mktd_pkg::SYM_DASH;
                end
            end
            if (n_sym != mktd_pkg::SYM_NONE) begin
                if (r_count < CNT_W'(MAX_SYMBOLS)) begin
                    if (n_sym == mktd_pkg::SYM_DASH) begin
                        n_bits = r_bits | (SYM_W'(1) << r_count);
                    end
                    n_count = r_count + CNT_W'(1);
                end else begin
                    n_overrun = 1'b1;
                end
            end
            n_await_rel = 1'b0;
            n_last      = s_axis_tdata;
            n_ovf       = 1'b0;
        end else begin
            // press: long gap or overflow closes the letter
            if (r_ovf || span > r_letter_gap) begin
                n_lend    = 1'b1;
                n_code    = lookup_code;
                n_cval    = (lookup_code != '0);
                n_bits    = '0;
                n_count   = '0;
                n_overrun = 1'b0;
            end
            n_await_rel = 1'b1;
            n_last      = s_axis_tdata;
            n_ovf       = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_min  <= mktd_pkg::SHORT_MIN_RST;
            r_dot_max    <= mktd_pkg::DOT_MAX_RST;
            r_dash_max   <= mktd_pkg::DASH_MAX_RST;
            r_letter_gap <= mktd_pkg::LETTER_GAP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                mktd_pkg::CFG_SHORT_MIN:  r_short_min  <= i_cfg_data;
                mktd_pkg::CFG_DOT_MAX:    r_dot_max    <= i_cfg_data;
                mktd_pkg::CFG_DASH_MAX:   r_dash_max   <= i_cfg_data;
                mktd_pkg::CFG_LETTER_GAP: r_letter_gap <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_await_rel <= 1'b0;
            r_last      <= '0;
            r_ovf       <= 1'b0;
            r_bits      <= '0;
            r_count     <= '0;
            r_overrun   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_await_rel <= n_await_rel;
                r_last      <= n_last;
                r_ovf       <= n_ovf;
                r_bits      <= n_bits;
                r_count     <= n_count;
                r_overrun   <= n_overrun;
            end
            if (s_axis_tready) begin
                r_out_valid <= accept && !s_axis_tuser;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !s_axis_tuser) begin
            r_sym  <= n_sym;
            r_lend <= n_lend;
            r_cval <= n_cval;
            r_code <= n_code;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_lend;
    assign m_axis_tdata  = {6'd0, r_code, r_cval, r_sym};

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_SYMBOLS))
        else $error("symbol count past limit");

    a_overrun_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_overrun |-> (r_count == CNT_W'(MAX_SYMBOLS)))
        else $error("overrun with room left");

    a_press_sets_await: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !s_axis_tuser && !r_await_rel) |=> r_await_rel)
        else $error("press did not arm release");

    a_close_no_symbol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_lend) |-> (r_sym == mktd_pkg::SYM_NONE))
        else $error("letter end carries a symbol");

    a_code_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_cval) |-> (r_code == '0))
        else $error("char code without char valid");

endmodule
